### design/tdpmr_pkg.sv
// ----------------------------------------------------------------------------
// tdpmr_pkg
// Types and constants shared by the TCP destination port match and rewrite
// block: register map, header offsets, item structures and the constants
// for the random-word reduction.
// ----------------------------------------------------------------------------
package tdpmr_pkg;

    // Configuration register map, one 32-bit word per register.
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_PORT_BASE     = 2'd0,
        REG_PORT_SPAN     = 2'd1,
        REG_NEW_PORT      = 2'd2,
        REG_HIT_THRESHOLD = 2'd3
    } t_reg_idx;

    localparam logic [15:0] PORT_BASE_RST     = 16'd6370;
    localparam logic [15:0] PORT_SPAN_RST     = 16'd16;
    localparam logic [15:0] NEW_PORT_RST      = 16'd5555;
    localparam logic [26:0] HIT_THRESHOLD_RST = 27'd10;

    // Header field values.
    localparam logic [7:0] ETHTYPE_HI = 8'h08;
    localparam logic [7:0] ETHTYPE_LO = 8'h00;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [3:0] IHL_MIN    = 4'd5;

    // Byte offsets within the frame (all fit in 7 bits).
    localparam logic [6:0] OFF_ETHTYPE_HI = 7'd12;
    localparam logic [6:0] OFF_ETHTYPE_LO = 7'd13;
    localparam logic [6:0] OFF_IHL        = 7'd14;
    localparam logic [6:0] OFF_PROTO      = 7'd23;
    // Ethernet header plus two bytes plus one: the low destination port byte
    // sits here when the IP header length is zero words.
    localparam logic [6:0] OFF_PORT_LO    = 7'd17;
    // Ethernet header plus minimum TCP header.
    localparam logic [6:0] ETH_TCP_BYTES  = 7'd34;

    // Random word reduction: quotient estimate by reciprocal multiply.
    localparam logic [26:0] RAND_MODULUS = 27'd100000000;
    localparam logic [9:0]  RECIP_MULT   = 10'd687;
    localparam int unsigned RECIP_SHIFT  = 36;
    localparam int unsigned QUOT_W       = 6;
    localparam int unsigned REM_W        = 28;

    // Result queue.
    localparam int unsigned FIFO_DEPTH = 4;

    typedef struct packed {
        logic [15:0] port_base;
        logic [15:0] port_span;
        logic [15:0] new_port;
        logic [26:0] hit_threshold;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [13:0] frame_length;
        logic [31:0] random_word;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_first;
        logic       out_last;
        logic       port_rewritten;
    } t_out_item;

    // Up to two result items produced by one accepted input item.
    typedef struct packed {
        logic [1:0]            count;
        t_out_item [1:0]       item;
    } t_push;

    typedef struct packed {
        logic headers_ok;
        logic rewrite_done;
    } t_parse_status;

endpackage

### design/tdpmr_in_if.sv
// ----------------------------------------------------------------------------
// tdpmr_in_if
// Valid/ready channel carrying one frame byte with its frame markers.
// ----------------------------------------------------------------------------
interface tdpmr_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [13:0] frame_length;
    logic [31:0] random_word;

    modport source (
        output valid, data_byte, first_byte, last_byte, frame_length, random_word,
        input  ready
    );

    modport sink (
        input  valid, data_byte, first_byte, last_byte, frame_length, random_word,
        output ready
    );
endinterface

### design/tdpmr_out_if.sv
// ----------------------------------------------------------------------------
// tdpmr_out_if
// Valid/ready channel carrying one output frame byte and its flags.
// ----------------------------------------------------------------------------
interface tdpmr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_first;
    logic       out_last;
    logic       port_rewritten;

    modport source (
        output valid, out_byte, out_first, out_last, port_rewritten,
        input  ready
    );

    modport sink (
        input  valid, out_byte, out_first, out_last, port_rewritten,
        output ready
    );
endinterface

### design/tdpmr_apb_regs.sv
// ----------------------------------------------------------------------------
// tdpmr_apb_regs
// APB-style register file holding the port window, the replacement port and
// the rewrite threshold.
// ----------------------------------------------------------------------------
module tdpmr_apb_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tdpmr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tdpmr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tdpmr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                               pready,
    output tdpmr_pkg::t_cfg                    o_cfg
);

    tdpmr_pkg::t_cfg      r_cfg;
    tdpmr_pkg::t_reg_idx  w_idx;
    logic                 w_write;

    assign w_idx   = tdpmr_pkg::t_reg_idx'(paddr[3:2]);
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.port_base     <= tdpmr_pkg::PORT_BASE_RST;
            r_cfg.port_span     <= tdpmr_pkg::PORT_SPAN_RST;
            r_cfg.new_port      <= tdpmr_pkg::NEW_PORT_RST;
            r_cfg.hit_threshold <= tdpmr_pkg::HIT_THRESHOLD_RST;
        end else if (w_write) begin
            unique case (w_idx)
                tdpmr_pkg::REG_PORT_BASE:     r_cfg.port_base     <= pwdata[15:0];
                tdpmr_pkg::REG_PORT_SPAN:     r_cfg.port_span     <= pwdata[15:0];
                tdpmr_pkg::REG_NEW_PORT:      r_cfg.new_port      <= pwdata[15:0];
                tdpmr_pkg::REG_HIT_THRESHOLD: r_cfg.hit_threshold <= pwdata[26:0];
                default: ;
            endcase
        end
    end

    // Read data is selected straight from the register file.
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            tdpmr_pkg::REG_PORT_BASE:     prdata = 32'(r_cfg.port_base);
            tdpmr_pkg::REG_PORT_SPAN:     prdata = 32'(r_cfg.port_span);
            tdpmr_pkg::REG_NEW_PORT:      prdata = 32'(r_cfg.new_port);
            tdpmr_pkg::REG_HIT_THRESHOLD: prdata = 32'(r_cfg.hit_threshold);
            default:                      prdata = '0;
        endcase
    end

endmodule

### design/tdpmr_rand_hit.sv
// ----------------------------------------------------------------------------
// tdpmr_rand_hit
// Reduces the frame's random word modulo 100000000 and compares the
// remainder with the threshold. Four pipeline stages: capture, quotient
// estimate, remainder, fold and compare.
// ----------------------------------------------------------------------------
module tdpmr_rand_hit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_random_word,
    input  logic [26:0] i_threshold,
    output logic        o_hit
);

    logic [31:0]                        r_x1;
    logic                               r_v1;
    logic [31:0]                        r_x2;
    logic [tdpmr_pkg::QUOT_W-1:0]       r_q2;
    logic                               r_v2;
    logic [tdpmr_pkg::REM_W-1:0]        r_rem3;
    logic                               r_v3;
    logic                               r_hit;

    logic [41:0]                        w_prod;
    logic [32:0]                        w_qm;
    logic [32:0]                        w_diff;
    logic [tdpmr_pkg::REM_W-1:0]        w_fold;

    // The quotient estimate is low by at most one; one subtract corrects it.
    assign w_prod = 42'(r_x1) * 42'(tdpmr_pkg::RECIP_MULT);
    assign w_qm   = 33'(r_q2) * 33'(tdpmr_pkg::RAND_MODULUS);
    assign w_diff = 33'(r_x2) - w_qm;
    assign w_fold = (r_rem3 >= tdpmr_pkg::REM_W'(tdpmr_pkg::RAND_MODULUS))
                  ? r_rem3 - tdpmr_pkg::REM_W'(tdpmr_pkg::RAND_MODULUS)
                  : r_rem3;
    assign o_hit  = r_hit;

    // Stage valids and the final flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v3) begin
                r_hit <= w_fold[26:0] < i_threshold;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x1 <= i_random_word;
        end
        r_x2   <= r_x1;
        r_q2   <= w_prod[tdpmr_pkg::RECIP_SHIFT +: tdpmr_pkg::QUOT_W];
        r_rem3 <= w_diff[tdpmr_pkg::REM_W-1:0];
    end

endmodule

### design/tdpmr_parse.sv
// ----------------------------------------------------------------------------
// tdpmr_parse
// Per-byte header checker and port rewriter. Tracks the byte offset and the
// header checks, holds one byte back and produces up to two result items
// for each accepted input item.
// ----------------------------------------------------------------------------
module tdpmr_parse #(
    parameter int unsigned MAX_FRAME_BYTES = 16384
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  tdpmr_pkg::t_in_item           i_item,
    input  tdpmr_pkg::t_cfg               i_cfg,
    input  logic                          i_random_hit,
    output tdpmr_pkg::t_push              o_push,
    output tdpmr_pkg::t_parse_status      o_status
);

    localparam int unsigned OFF_W = $clog2(MAX_FRAME_BYTES);
    localparam int unsigned CMP_W = (OFF_W > 7) ? OFF_W : 7;
    localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_FRAME_BYTES - 1);

    logic [OFF_W-1:0]  r_byte_offset, n_byte_offset;
    logic [13:0]       r_frame_len,   n_frame_len;
    logic [3:0]        r_ip_header_words, n_ip_header_words;
    logic              r_ethertype_high_ok, n_ethertype_high_ok;
    logic              r_headers_ok,  n_headers_ok;
    logic [7:0]        r_held_byte,   n_held_byte;
    logic              r_held_valid,  n_held_valid;
    logic              r_held_is_first, n_held_is_first;
    logic              r_rewrite_done, n_rewrite_done;

    logic [OFF_W-1:0]  w_off;
    logic [CMP_W-1:0]  w_off_x;
    logic [6:0]        w_port_lo_off;
    logic [6:0]        w_need_len;
    logic              w_hv;
    logic              w_flush;
    logic              w_rwd;
    logic [15:0]       w_port;
    logic [16:0]       w_port_end;
    logic              w_in_range;
    logic              w_do_rw;
    logic [7:0]        w_held_out;
    logic [7:0]        w_cur;
    logic              w_a_valid;
    tdpmr_pkg::t_out_item w_a;
    tdpmr_pkg::t_out_item w_b;

    always_comb begin
        // A first byte restarts all per-frame state.
        w_off               = i_item.first_byte ? '0 : r_byte_offset;
        w_off_x             = CMP_W'(w_off);
        w_hv                = r_held_valid && !i_item.first_byte;
        w_flush             = r_held_valid && i_item.first_byte;
        w_rwd               = r_rewrite_done && !i_item.first_byte;
        n_frame_len         = i_item.first_byte ? i_item.frame_length : r_frame_len;
        n_ethertype_high_ok = r_ethertype_high_ok && !i_item.first_byte;
        n_headers_ok        = r_headers_ok && !i_item.first_byte;
        n_ip_header_words   = i_item.first_byte ? 4'd0 : r_ip_header_words;
        w_need_len          = '0;

        // Header checks at fixed offsets.
        case (w_off_x)
            CMP_W'(tdpmr_pkg::OFF_ETHTYPE_HI): begin
                n_ethertype_high_ok = i_item.data_byte == tdpmr_pkg::ETHTYPE_HI;
            end
            CMP_W'(tdpmr_pkg::OFF_ETHTYPE_LO): begin
                n_headers_ok = n_ethertype_high_ok
                             && (i_item.data_byte == tdpmr_pkg::ETHTYPE_LO);
            end
            CMP_W'(tdpmr_pkg::OFF_IHL): begin
                n_ip_header_words = i_item.data_byte[3:0];
                w_need_len        = tdpmr_pkg::ETH_TCP_BYTES
                                  + {1'b0, i_item.data_byte[3:0], 2'b00};
                n_headers_ok      = n_headers_ok
                                  && (i_item.data_byte[3:0] >= tdpmr_pkg::IHL_MIN)
                                  && ({7'd0, w_need_len} <= n_frame_len);
            end
            CMP_W'(tdpmr_pkg::OFF_PROTO): begin
                n_headers_ok = n_headers_ok && (i_item.data_byte == tdpmr_pkg::PROTO_TCP);
            end
            default: ;
        endcase

        // Port match on the low port byte, with the high byte still held.
        w_port_lo_off = tdpmr_pkg::OFF_PORT_LO + {1'b0, n_ip_header_words, 2'b00};
        w_port        = {r_held_byte, i_item.data_byte};
        w_port_end    = {1'b0, i_cfg.port_base} + {1'b0, i_cfg.port_span};
        w_in_range    = (w_port >= i_cfg.port_base) && ({1'b0, w_port} < w_port_end);
        w_do_rw       = (w_off_x == CMP_W'(w_port_lo_off)) && n_headers_ok
                      && i_random_hit && w_hv && !w_rwd && w_in_range;
        w_held_out    = w_do_rw ? i_cfg.new_port[15:8] : r_held_byte;
        w_cur         = w_do_rw ? i_cfg.new_port[7:0]  : i_item.data_byte;
        n_rewrite_done = w_rwd || w_do_rw;

        // First slot: a flushed byte of the previous frame or the held byte.
        w_a_valid = w_flush || w_hv;
        if (w_flush) begin
            w_a.out_byte       = r_held_byte;
            w_a.out_first      = r_held_is_first;
            w_a.out_last       = 1'b1;
            w_a.port_rewritten = r_rewrite_done;
        end else begin
            w_a.out_byte       = w_held_out;
            w_a.out_first      = r_held_is_first;
            w_a.out_last       = 1'b0;
            w_a.port_rewritten = n_rewrite_done;
        end

        // Second slot: the current byte when it closes the frame.
        w_b.out_byte       = w_cur;
        w_b.out_first      = i_item.first_byte;
        w_b.out_last       = 1'b1;
        w_b.port_rewritten = n_rewrite_done;

        o_push.item[0] = w_a_valid ? w_a : w_b;
        o_push.item[1] = w_b;
        o_push.count   = i_accept
                       ? ({1'b0, w_a_valid} + {1'b0, i_item.last_byte}) : 2'd0;

        // Hold the current byte unless it ends the frame.
        if (i_item.last_byte) begin
            n_held_byte     = r_held_byte;
            n_held_valid    = 1'b0;
            n_held_is_first = 1'b0;
        end else begin
            n_held_byte     = w_cur;
            n_held_valid    = 1'b1;
            n_held_is_first = i_item.first_byte;
        end

        n_byte_offset = (w_off < OFF_MAX) ? w_off + 1'b1 : w_off;
    end

    assign o_status.headers_ok   = r_headers_ok;
    assign o_status.rewrite_done = r_rewrite_done;

    // Frame state advances once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset       <= '0;
            r_frame_len         <= '0;
            r_ip_header_words   <= '0;
            r_ethertype_high_ok <= 1'b0;
            r_headers_ok        <= 1'b0;
            r_held_valid        <= 1'b0;
            r_held_is_first     <= 1'b0;
            r_rewrite_done      <= 1'b0;
        end else if (i_accept) begin
            r_byte_offset       <= n_byte_offset;
            r_frame_len         <= n_frame_len;
            r_ip_header_words   <= n_ip_header_words;
            r_ethertype_high_ok <= n_ethertype_high_ok;
            r_headers_ok        <= n_headers_ok;
            r_held_valid        <= n_held_valid;
            r_held_is_first     <= n_held_is_first;
            r_rewrite_done      <= n_rewrite_done;
        end
    end

    // The held byte is payload and needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held_byte <= n_held_byte;
        end
    end

endmodule

### design/tdpmr_out_fifo.sv
// ----------------------------------------------------------------------------
// tdpmr_out_fifo
// Four-entry result queue. Takes up to two items per cycle, releases one per
// cycle on the output channel while it is ready, and asks for input only
// while at least two entries are free.
// ----------------------------------------------------------------------------
module tdpmr_out_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tdpmr_pkg::t_push      i_push,
    output logic                  o_ready,
    tdpmr_out_if.source           o_out
);

    localparam int unsigned PTR_W = $clog2(tdpmr_pkg::FIFO_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    tdpmr_pkg::t_out_item  r_mem [tdpmr_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]      r_wptr, n_wptr;
    logic [PTR_W-1:0]      r_rptr, n_rptr;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  w_pop;
    logic [PTR_W-1:0]      w_wptr1;
    tdpmr_pkg::t_out_item  w_head;

    assign w_pop   = o_out.valid && o_out.ready;
    assign w_wptr1 = r_wptr + 1'b1;
    assign o_ready = r_count <= CNT_W'(tdpmr_pkg::FIFO_DEPTH - 2);

    // Head entry drives the output channel.
    assign w_head               = r_mem[r_rptr];
    assign o_out.valid          = r_count != '0;
    assign o_out.out_byte       = w_head.out_byte;
    assign o_out.out_first      = w_head.out_first;
    assign o_out.out_last       = w_head.out_last;
    assign o_out.port_rewritten = w_head.port_rewritten;

    // Pointer and fill count updates.
    always_comb begin
        n_wptr  = r_wptr + PTR_W'(i_push.count);
        n_rptr  = w_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + CNT_W'(i_push.count) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage writes, one or two entries per cycle.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wptr] <= i_push.item[0];
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wptr1] <= i_push.item[1];
        end
    end

endmodule

### design/tcp_dest_port_match_rewrite.sv
// ----------------------------------------------------------------------------
// tcp_dest_port_match_rewrite
// Ethernet/IPv4/TCP destination port classifier. Frames stream through one
// byte per item; a destination port in the configured window is replaced
// by the new port when the frame's random word selects it.
//
//   channel   dir  handshake          payload
//   i_in      in   valid/ready        data_byte, first_byte, last_byte,
//                                     frame_length, random_word
//   o_out     out  valid/ready        out_byte, out_first, out_last,
//                                     port_rewritten
//   apb       in   psel/penable/      paddr, pwdata, prdata
//                  pready
//
// One input item is taken per cycle while the result queue has room. Output
// lags by one item: a byte is held until the next byte (or the end of the
// frame) is known. The four-entry result queue takes up to two items a cycle
// and drops ready only while more than two entries are full. The random-word
// check is ready long before the port bytes arrive. Reset is synchronous and
// empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tcp_dest_port_match_rewrite #(
    parameter int unsigned MAX_FRAME_BYTES = 16384
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    tdpmr_in_if.sink                           i_in,
    tdpmr_out_if.source                        o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tdpmr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tdpmr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tdpmr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                               pready
);

    tdpmr_pkg::t_cfg           w_cfg;
    tdpmr_pkg::t_in_item       w_item;
    tdpmr_pkg::t_push          w_push;
    tdpmr_pkg::t_parse_status  w_status;
    logic                      w_ready;
    logic                      w_accept;
    logic                      w_random_hit;

    assign i_in.ready          = w_ready;
    assign w_accept            = i_in.valid && w_ready;
    assign w_item.data_byte    = i_in.data_byte;
    assign w_item.first_byte   = i_in.first_byte;
    assign w_item.last_byte    = i_in.last_byte;
    assign w_item.frame_length = i_in.frame_length;
    assign w_item.random_word  = i_in.random_word;

    // Configuration registers.
    tdpmr_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Random selection, started by each frame's first byte.
    tdpmr_rand_hit u_rand (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_accept && i_in.first_byte),
        .i_random_word (i_in.random_word),
        .i_threshold   (w_cfg.hit_threshold),
        .o_hit         (w_random_hit)
    );

    // Header checks, port rewrite and one-byte hold.
    tdpmr_parse #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_item       (w_item),
        .i_cfg        (w_cfg),
        .i_random_hit (w_random_hit),
        .o_push       (w_push),
        .o_status     (w_status)
    );

    // Result queue feeding the output channel.
    tdpmr_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_ready),
        .o_out   (o_out)
    );

    // A frame-closing item always leaves at least one result queued.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last_byte) |=> o_out.valid)
        else $error("last byte accepted but no result queued");

    // The first byte of a frame leaves before any rewrite of that frame.
    a_first_not_rewritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_first) |-> !o_out.port_rewritten)
        else $error("first output byte flagged as rewritten");

    // A rewrite happens only on a frame with good headers and a random hit.
    a_rewrite_qualified: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_status.rewrite_done) |-> (w_status.headers_ok && w_random_hit))
        else $error("port rewritten without header pass or random hit");

endmodule
